/* sv/dfmc_pkg.sv */
// ----------------------------------------------------------------------------
// Dual fuel mode controller package
// Shared constants, codes and structure types for the mode controller.
// ----------------------------------------------------------------------------
package dfmc_pkg;

   localparam int TICKS_PER_MINUTE_DEF = 1000000 * 60;
   localparam int STAMP_BITS           = 16;
   localparam int ADC_BITS             = 12;
   localparam int RPM_BITS             = 16;
   localparam int BLINK_BITS           = 8;
   localparam int BAR_BITS             = 4;
   localparam int CSR_INDEX_BITS       = 3;
   localparam int CSR_DATA_BITS        = 16;

   localparam logic [RPM_BITS-1:0] RPM_MAX = 16'hFFFF;

   localparam logic [ADC_BITS-1:0]   GAUGE_LEVEL_1_RST = ADC_BITS'(1241 / 2);
   localparam logic [ADC_BITS-1:0]   GAUGE_LEVEL_2_RST = ADC_BITS'(2482 / 2);
   localparam logic [ADC_BITS-1:0]   GAUGE_LEVEL_3_RST = ADC_BITS'(3722 / 2);
   localparam logic [ADC_BITS-1:0]   GAUGE_LEVEL_4_RST = ADC_BITS'(4964 / 2);
   localparam logic [RPM_BITS-1:0]   RPM_ENGAGE_RST    = RPM_BITS'(2400);
   localparam logic [RPM_BITS-1:0]   RPM_RELEASE_RST   = RPM_BITS'(600);
   localparam logic [BLINK_BITS-1:0] BLINK_TICKS_RST   = BLINK_BITS'(400 / 10);

   localparam logic [BAR_BITS-1:0] BARS_NONE  = 4'b0000;
   localparam logic [BAR_BITS-1:0] BARS_ONE   = 4'b0001;
   localparam logic [BAR_BITS-1:0] BARS_TWO   = 4'b0011;
   localparam logic [BAR_BITS-1:0] BARS_THREE = 4'b0111;
   localparam logic [BAR_BITS-1:0] BARS_FOUR  = 4'b1111;

   typedef enum logic [1:0] {
      MODE_PETROL = 2'd0,
      MODE_STOP   = 2'd1,
      MODE_RUN    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DIVIDE = 2'd1,
      ST_FINISH = 2'd2
   } seq_state_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_GAUGE_LEVEL_1 = 3'd0,
      REG_GAUGE_LEVEL_2 = 3'd1,
      REG_GAUGE_LEVEL_3 = 3'd2,
      REG_GAUGE_LEVEL_4 = 3'd3,
      REG_RPM_ENGAGE    = 3'd4,
      REG_RPM_RELEASE   = 3'd5,
      REG_BLINK_TICKS   = 3'd6
   } reg_index_type;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_CAPTURE = 1'b1;

   typedef struct packed {
      logic [ADC_BITS-1:0]   gauge_level_1;
      logic [ADC_BITS-1:0]   gauge_level_2;
      logic [ADC_BITS-1:0]   gauge_level_3;
      logic [ADC_BITS-1:0]   gauge_level_4;
      logic [RPM_BITS-1:0]   rpm_engage;
      logic [RPM_BITS-1:0]   rpm_release;
      logic [BLINK_BITS-1:0] blink_ticks;
   } cfg_type;

   typedef struct packed {
      mode_type              mode;
      logic                  switch_was_pressed;
      logic [BLINK_BITS-1:0] blink_count;
      logic                  lamp_gas;
      logic [BAR_BITS-1:0]   bars;
   } tick_state_type;

   typedef struct packed {
      logic                  start;
      logic [STAMP_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [RPM_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/dfmc_if.sv */
// ----------------------------------------------------------------------------
// Dual fuel mode controller channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface dfmc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic                           switch_pressed;
   logic [dfmc_pkg::ADC_BITS-1:0]   pressure;
   logic [dfmc_pkg::STAMP_BITS-1:0] capture_time;

   modport source (output valid, kind, switch_pressed, pressure, capture_time, input ready);
   modport sink (input valid, kind, switch_pressed, pressure, capture_time, output ready);
endinterface

interface dfmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    fuel_mode;
   logic                          gas_valve;
   logic                          gas_lamp;
   logic                          petrol_lamp;
   logic [dfmc_pkg::BAR_BITS-1:0] gauge_bars;
   logic [dfmc_pkg::RPM_BITS-1:0] engine_rpm;

   modport source (output valid, fuel_mode, gas_valve, gas_lamp, petrol_lamp, gauge_bars,
                   engine_rpm, input ready);
   modport sink (input valid, fuel_mode, gas_valve, gas_lamp, petrol_lamp, gauge_bars,
                 engine_rpm, output ready);
endinterface

/* sv/dfmc_div.sv */
// ----------------------------------------------------------------------------
// Engine speed divider
// Restoring shift and subtract divider, one quotient bit per cycle, that
// divides the ticks per minute constant by a stamp period and saturates.
// ----------------------------------------------------------------------------
module dfmc_div #(
   parameter int TICKS_PER_MINUTE = dfmc_pkg::TICKS_PER_MINUTE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dfmc_pkg::div_req_type req,
   output dfmc_pkg::div_rsp_type rsp
);

   localparam int DW = $clog2(TICKS_PER_MINUTE + 1);
   localparam int CW = $clog2(DW);
   localparam int QW = (DW > dfmc_pkg::RPM_BITS) ? DW : dfmc_pkg::RPM_BITS;
   localparam int SB = dfmc_pkg::STAMP_BITS;
   localparam logic [DW-1:0] DIVIDEND = DW'(TICKS_PER_MINUTE);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SB-1:0] rem_ff, rem_in;
   logic [SB-1:0] dsr_ff, dsr_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SB:0]   trial;
   logic [SB:0]   diff;
   logic          fits;
   logic [QW-1:0] quo_ext;

   always_comb begin
      trial = {rem_ff, DIVIDEND[cnt_ff]};
      diff  = trial - {1'b0, dsr_ff};
      fits  = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
         rem_in  = '0;
         dsr_in  = req.divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SB-1:0] : trial[SB-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign quo_ext = QW'(quo_ff);

   always_comb begin
      rsp.done = done_ff;
      if ((quo_ext >> dfmc_pkg::RPM_BITS) != '0) begin
         rsp.quotient = dfmc_pkg::RPM_MAX;
      end else begin
         rsp.quotient = quo_ext[dfmc_pkg::RPM_BITS-1:0];
      end
   end

endmodule

/* sv/dfmc_tick.sv */
// ----------------------------------------------------------------------------
// Tick update logic
// Next mode, blink, lamp and gauge state for one tick word.
// ----------------------------------------------------------------------------
module dfmc_tick (
   input  dfmc_pkg::cfg_type                cfg,
   input  dfmc_pkg::tick_state_type         cur,
   input  logic [dfmc_pkg::RPM_BITS-1:0]    speed,
   input  logic                             switch_pressed,
   input  logic [dfmc_pkg::ADC_BITS-1:0]    pressure,
   output dfmc_pkg::tick_state_type         nxt
);

   logic                              press_edge;
   logic [dfmc_pkg::BLINK_BITS-1:0]   blink_inc;
   logic [dfmc_pkg::BAR_BITS-1:0]     gauge;

   // A sample in no band, as at a threshold of ordered levels, keeps the bars.
   always_comb begin
      gauge = cur.bars;
      if (pressure < cfg.gauge_level_1) begin
         gauge = dfmc_pkg::BARS_NONE;
      end else if (pressure > cfg.gauge_level_1 && pressure < cfg.gauge_level_2) begin
         gauge = dfmc_pkg::BARS_ONE;
      end else if (pressure > cfg.gauge_level_2 && pressure < cfg.gauge_level_3) begin
         gauge = dfmc_pkg::BARS_TWO;
      end else if (pressure > cfg.gauge_level_3 && pressure < cfg.gauge_level_4) begin
         gauge = dfmc_pkg::BARS_THREE;
      end else if (pressure > cfg.gauge_level_4) begin
         gauge = dfmc_pkg::BARS_FOUR;
      end
   end

   always_comb begin
      press_edge = switch_pressed & ~cur.switch_was_pressed;
      blink_inc  = cur.blink_count + 1'b1;
      nxt        = cur;
      nxt.switch_was_pressed = switch_pressed;
      case (cur.mode)
         dfmc_pkg::MODE_STOP: begin
            if (blink_inc >= cfg.blink_ticks) begin
               nxt.blink_count = '0;
               nxt.lamp_gas    = ~cur.lamp_gas;
            end else begin
               nxt.blink_count = blink_inc;
            end
            nxt.bars = gauge;
            if (press_edge) begin
               nxt.mode = dfmc_pkg::MODE_PETROL;
            end else if (speed >= cfg.rpm_engage) begin
               nxt.mode = dfmc_pkg::MODE_RUN;
            end
         end
         dfmc_pkg::MODE_RUN: begin
            nxt.lamp_gas = 1'b1;
            nxt.bars     = gauge;
            if (press_edge) begin
               nxt.mode = dfmc_pkg::MODE_PETROL;
            end else if (speed <= cfg.rpm_release) begin
               nxt.mode = dfmc_pkg::MODE_STOP;
            end
         end
         default: begin
            nxt.lamp_gas = 1'b0;
            nxt.bars     = dfmc_pkg::BARS_NONE;
            nxt.mode     = press_edge ? dfmc_pkg::MODE_STOP : dfmc_pkg::MODE_PETROL;
         end
      endcase
   end

endmodule

/* sv/dual_fuel_mode_controller_top.sv */
// ----------------------------------------------------------------------------
// Dual fuel mode controller
// Petrol/gas mode, gas lamp, valve, pressure gauge and engine speed.
// ----------------------------------------------------------------------------
// Words arrive on req_chan: a tick carries the switch level and a pressure
// sample, a capture carries a timer stamp of an engine edge. Every word gives
// exactly one result word on rsp_chan with the mode, lamps, valve, gauge bars
// and engine speed after that word.
// A tick, or a capture that does not divide, goes from acceptance straight
// to the finish state. A capture with an earlier stamp held and a nonzero
// period first runs the divider in the divide state, one quotient bit per
// cycle. The block holds one word at a time; ready is low from acceptance
// until its result has entered the output register. A stalled receiver
// leaves the result in that register; the next word is still taken and
// processed, and the block then waits with ready low until the register is
// free. Registers are to be written by the user through csr_we, csr_index
// and csr_wdata only while idle; the block does not enforce it. Reset is
// synchronous: petrol mode, gauge cleared, speed zero, no stamp held,
// registers at their defaults and no result pending.
// ----------------------------------------------------------------------------
module dual_fuel_mode_controller_top #(
   parameter int TICKS_PER_MINUTE = dfmc_pkg::TICKS_PER_MINUTE_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dfmc_req_if.sink                             req_chan,
   dfmc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [dfmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dfmc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int SB = dfmc_pkg::STAMP_BITS;
   localparam int RB = dfmc_pkg::RPM_BITS;

   dfmc_pkg::seq_state_type  state_ff, state_in;
   dfmc_pkg::cfg_type        cfg_ff, cfg_in;
   dfmc_pkg::tick_state_type tick_ff, tick_in, tick_nxt;
   logic [SB-1:0]            last_stamp_ff, last_stamp_in;
   logic                     have_stamp_ff, have_stamp_in;
   logic [RB-1:0]            speed_ff, speed_in;

   logic                     out_valid_ff, out_valid_in;
   logic [1:0]               out_mode_ff, out_mode_in;
   logic                     out_valve_ff, out_valve_in;
   logic                     out_gas_lamp_ff, out_gas_lamp_in;
   logic                     out_petrol_lamp_ff, out_petrol_lamp_in;
   logic [dfmc_pkg::BAR_BITS-1:0] out_bars_ff, out_bars_in;
   logic [RB-1:0]            out_rpm_ff, out_rpm_in;

   logic                     accept;
   logic                     is_capture;
   logic [SB-1:0]            period;
   logic                     need_divide;
   logic                     load_out;
   logic                     is_run;
   logic                     is_stop;
   dfmc_pkg::div_req_type    div_req;
   dfmc_pkg::div_rsp_type    div_rsp;

   assign accept      = req_chan.valid && req_chan.ready;
   assign is_capture  = (req_chan.kind == dfmc_pkg::KIND_CAPTURE);
   assign period      = req_chan.capture_time - last_stamp_ff;
   assign need_divide = is_capture && have_stamp_ff && (period != '0);

   dfmc_tick u_tick (
      .cfg            (cfg_ff),
      .cur            (tick_ff),
      .speed          (speed_ff),
      .switch_pressed (req_chan.switch_pressed),
      .pressure       (req_chan.pressure),
      .nxt            (tick_nxt)
   );

   dfmc_div #(
      .TICKS_PER_MINUTE (TICKS_PER_MINUTE)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dfmc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = need_divide ? dfmc_pkg::ST_DIVIDE : dfmc_pkg::ST_FINISH;
            end
         end
         dfmc_pkg::ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = dfmc_pkg::ST_FINISH;
            end
         end
         dfmc_pkg::ST_FINISH: begin
            if (load_out) begin
               state_in = dfmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfmc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_chan.ready  = 1'b0;
      load_out        = 1'b0;
      div_req.start   = 1'b0;
      div_req.divisor = period;
      case (state_ff)
         dfmc_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_req.start  = req_chan.valid && need_divide;
         end
         dfmc_pkg::ST_FINISH: begin
            load_out = !out_valid_ff || rsp_chan.ready;
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dfmc_pkg::REG_GAUGE_LEVEL_1: cfg_in.gauge_level_1 = csr_wdata[dfmc_pkg::ADC_BITS-1:0];
            dfmc_pkg::REG_GAUGE_LEVEL_2: cfg_in.gauge_level_2 = csr_wdata[dfmc_pkg::ADC_BITS-1:0];
            dfmc_pkg::REG_GAUGE_LEVEL_3: cfg_in.gauge_level_3 = csr_wdata[dfmc_pkg::ADC_BITS-1:0];
            dfmc_pkg::REG_GAUGE_LEVEL_4: cfg_in.gauge_level_4 = csr_wdata[dfmc_pkg::ADC_BITS-1:0];
            dfmc_pkg::REG_RPM_ENGAGE:    cfg_in.rpm_engage    = csr_wdata[RB-1:0];
            dfmc_pkg::REG_RPM_RELEASE:   cfg_in.rpm_release   = csr_wdata[RB-1:0];
            dfmc_pkg::REG_BLINK_TICKS:   cfg_in.blink_ticks   =
                                            csr_wdata[dfmc_pkg::BLINK_BITS-1:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      tick_in       = tick_ff;
      last_stamp_in = last_stamp_ff;
      have_stamp_in = have_stamp_ff;
      speed_in      = speed_ff;
      if (accept) begin
         if (is_capture) begin
            have_stamp_in = 1'b1;
            last_stamp_in = req_chan.capture_time;
         end else begin
            tick_in = tick_nxt;
         end
      end
      if (state_ff == dfmc_pkg::ST_DIVIDE && div_rsp.done) begin
         speed_in = div_rsp.quotient;
      end
   end

   always_comb begin
      is_run             = (tick_ff.mode == dfmc_pkg::MODE_RUN);
      is_stop            = (tick_ff.mode == dfmc_pkg::MODE_STOP);
      out_valid_in       = out_valid_ff;
      out_mode_in        = out_mode_ff;
      out_valve_in       = out_valve_ff;
      out_gas_lamp_in    = out_gas_lamp_ff;
      out_petrol_lamp_in = out_petrol_lamp_ff;
      out_bars_in        = out_bars_ff;
      out_rpm_in         = out_rpm_ff;
      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in       = 1'b1;
         out_mode_in        = is_run  ? dfmc_pkg::MODE_RUN :
                              is_stop ? dfmc_pkg::MODE_STOP : dfmc_pkg::MODE_PETROL;
         out_valve_in       = is_run;
         out_gas_lamp_in    = is_run || (is_stop && tick_ff.lamp_gas);
         out_petrol_lamp_in = !is_run && !is_stop;
         out_bars_in        = (is_run || is_stop) ? tick_ff.bars : dfmc_pkg::BARS_NONE;
         out_rpm_in         = speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                    <= dfmc_pkg::ST_IDLE;
         cfg_ff.gauge_level_1        <= dfmc_pkg::GAUGE_LEVEL_1_RST;
         cfg_ff.gauge_level_2        <= dfmc_pkg::GAUGE_LEVEL_2_RST;
         cfg_ff.gauge_level_3        <= dfmc_pkg::GAUGE_LEVEL_3_RST;
         cfg_ff.gauge_level_4        <= dfmc_pkg::GAUGE_LEVEL_4_RST;
         cfg_ff.rpm_engage           <= dfmc_pkg::RPM_ENGAGE_RST;
         cfg_ff.rpm_release          <= dfmc_pkg::RPM_RELEASE_RST;
         cfg_ff.blink_ticks          <= dfmc_pkg::BLINK_TICKS_RST;
         tick_ff.mode                <= dfmc_pkg::MODE_PETROL;
         tick_ff.switch_was_pressed  <= 1'b0;
         tick_ff.blink_count         <= '0;
         tick_ff.lamp_gas            <= 1'b0;
         tick_ff.bars                <= dfmc_pkg::BARS_NONE;
         last_stamp_ff               <= '0;
         have_stamp_ff               <= 1'b0;
         speed_ff                    <= '0;
         out_valid_ff                <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_ff        <= cfg_in;
         tick_ff       <= tick_in;
         last_stamp_ff <= last_stamp_in;
         have_stamp_ff <= have_stamp_in;
         speed_ff      <= speed_in;
         out_valid_ff  <= out_valid_in;
      end
      out_mode_ff        <= out_mode_in;
      out_valve_ff       <= out_valve_in;
      out_gas_lamp_ff    <= out_gas_lamp_in;
      out_petrol_lamp_ff <= out_petrol_lamp_in;
      out_bars_ff        <= out_bars_in;
      out_rpm_ff         <= out_rpm_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.fuel_mode   = out_mode_ff;
   assign rsp_chan.gas_valve   = out_valve_ff;
   assign rsp_chan.gas_lamp    = out_gas_lamp_ff;
   assign rsp_chan.petrol_lamp = out_petrol_lamp_ff;
   assign rsp_chan.gauge_bars  = out_bars_ff;
   assign rsp_chan.engine_rpm  = out_rpm_ff;

endmodule

/* sv/dfmc_checker.sv */
// ----------------------------------------------------------------------------
// Dual fuel mode controller checker
// Port level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module dfmc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    fuel_mode,
   input logic                          gas_valve,
   input logic                          gas_lamp,
   input logic                          petrol_lamp,
   input logic [dfmc_pkg::BAR_BITS-1:0] gauge_bars,
   input logic [dfmc_pkg::RPM_BITS-1:0] engine_rpm
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(fuel_mode) && $stable(engine_rpm)
         && $stable(gauge_bars))
      else $error("A stalled result word changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A new word was taken before the previous one finished.");

   a_valve_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (gas_valve == (fuel_mode == dfmc_pkg::MODE_RUN))
         && (petrol_lamp == (fuel_mode == dfmc_pkg::MODE_PETROL)))
      else $error("Valve or petrol lamp disagree with the fuel mode.");

   a_petrol_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fuel_mode == dfmc_pkg::MODE_PETROL |-> !gas_lamp && gauge_bars == '0)
      else $error("Gas lamp or gauge lit in petrol mode.");

endmodule

bind dual_fuel_mode_controller_top dfmc_checker u_dfmc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .fuel_mode   (rsp_chan.fuel_mode),
   .gas_valve   (rsp_chan.gas_valve),
   .gas_lamp    (rsp_chan.gas_lamp),
   .petrol_lamp (rsp_chan.petrol_lamp),
   .gauge_bars  (rsp_chan.gauge_bars),
   .engine_rpm  (rsp_chan.engine_rpm)
);
